// ===== rtl/core/atrlc_pkg.sv =====
// Shared constants, codes, types and match patterns for the AT response
// line classifier. No dependencies; every other file imports this package.
`default_nettype none

package atrlc_pkg;

   // Line store geometry.
   localparam int BUF_DEPTH = 256;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);
   localparam int FILL_W    = ADDR_W + 1;
   localparam int CMP_W     = (FILL_W > 8) ? FILL_W : 8;

   // Field widths of the beats.
   localparam int FUNC_W = 2;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 8;
   localparam int CODE_W = 3;
   localparam int LEN_W  = 9;

   // Item functions.
   localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SILENCE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

   // Result codes; the pattern codes equal the pattern numbers.
   localparam logic [CODE_W-1:0] CODE_OK       = 3'd0;
   localparam logic [CODE_W-1:0] CODE_ERROR    = 3'd1;
   localparam logic [CODE_W-1:0] CODE_RING     = 3'd2;
   localparam logic [CODE_W-1:0] CODE_READY    = 3'd3;
   localparam logic [CODE_W-1:0] CODE_HWFAIL   = 3'd4;
   localparam logic [CODE_W-1:0] CODE_NORESP   = 3'd5;
   localparam logic [CODE_W-1:0] CODE_OVERFLOW = 3'd6;
   localparam logic [CODE_W-1:0] CODE_READ     = 3'd7;

   localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;

   // Final result lines, padded to sixteen bytes.
   localparam int NPAT    = 5;
   localparam int PAT_MAX = 16;
   localparam logic [NPAT-1:0] ALL_ALIVE = '1;

   localparam logic [4:0] PAT_LEN [NPAT] = '{5'd4, 5'd7, 5'd9, 5'd7, 5'd16};

   localparam logic [7:0] PAT_TEXT [NPAT][PAT_MAX] = '{
      '{"O", "K", 8'd13, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{"E", "R", "R", "O", "R", 8'd13, 8'd10, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{"S", "B", "D", "R", "I", "N", "G", 8'd13,
        8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{"R", "E", "A", "D", "Y", 8'd13, 8'd10, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{"H", "A", "R", "D", "W", "A", "R", "E",
        " ", "F", "A", "I", "L", "U", "R", "E"}
   };

   // Per-beat command from the line tracker to the datapath.
   typedef struct packed {
      logic              emit;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              rd_hit;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/atrlc_ifs.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on atrlc_pkg for field widths.
`default_nettype none

interface atrlc_req_if;
   import atrlc_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [BYTE_W-1:0] rx_byte;
   logic [IDX_W-1:0]  read_index;
   modport source (output valid, func, rx_byte, read_index, input ready);
   modport sink (input valid, func, rx_byte, read_index, output ready);
endinterface

interface atrlc_rsp_if;
   import atrlc_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] result_code;
   logic [LEN_W-1:0]  info_length;
   logic [BYTE_W-1:0] data_byte;
   modport source (output valid, result_code, info_length, data_byte, input ready);
   modport sink (input valid, result_code, info_length, data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/at_response_line_classifier.sv =====
// AT response line classifier. Depends on atrlc_pkg, atrlc_ifs,
// atrlc_tracker and atrlc_line_store.
//
// Takes one request beat per clock, unless the result stage and output
// register are both full, and gives at most one response beat for it
// through them. All line state sits in flops updated at acceptance, so the
// next byte sees it at once; the store's registered read port feeds a read
// beat's data to the output register. These registers decouple the sides,
// so requests keep flowing while a response waits. Reads at or past the
// fill position return zero. No clearing pass is needed.
`default_nettype none

module at_response_line_classifier (
   input  wire         clock,
   input  wire         reset,
   atrlc_req_if.sink   req,
   atrlc_rsp_if.source rsp
);
   import atrlc_pkg::*;

   cmd_type           cmd;
   logic [BYTE_W-1:0] rd_data;
   logic              accept;
   logic              advance;

   logic              s1_valid_ff, s1_valid_in;
   logic [CODE_W-1:0] s1_code_ff, s1_code_in;
   logic [LEN_W-1:0]  s1_len_ff, s1_len_in;
   logic              s1_hit_ff, s1_hit_in;

   logic              out_valid_ff, out_valid_in;
   logic [CODE_W-1:0] out_code_ff, out_code_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   atrlc_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .func       (req.func),
      .rx_byte    (req.rx_byte),
      .read_index (req.read_index),
      .cmd        (cmd)
   );

   atrlc_line_store u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_code_in  = s1_code_ff;
      s1_len_in   = s1_len_ff;
      s1_hit_in   = s1_hit_ff;
      if (accept) begin
         s1_valid_in = cmd.emit;
         s1_code_in  = cmd.code;
         s1_len_in   = cmd.len;
         s1_hit_in   = cmd.rd_en && cmd.rd_hit;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_code_in  = out_code_ff;
      out_len_in   = out_len_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         out_code_in  = s1_code_ff;
         out_len_in   = s1_len_ff;
         // The read data is held by the store until the next read beat.
         out_data_in  = s1_hit_ff ? rd_data : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_code_ff  <= s1_code_in;
      s1_len_ff   <= s1_len_in;
      s1_hit_ff   <= s1_hit_in;
      out_code_ff <= out_code_in;
      out_len_ff  <= out_len_in;
      out_data_ff <= out_data_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_code = out_code_ff;
   assign rsp.info_length = out_len_ff;
   assign rsp.data_byte   = out_data_ff;

   a_read_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_code == CODE_READ |-> rsp.info_length == '0)
      else $error("read beat carries a nonzero information length");

   a_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_code != CODE_READ |-> rsp.data_byte == '0)
      else $error("non-read beat carries data");

   a_silence_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req.func == FUNC_SILENCE |=> s1_valid_ff)
      else $error("silence beat produced no result");

   a_ready_only_stalled: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp.valid && !rsp.ready && s1_valid_ff))
      else $error("request side blocked without a stalled response");

endmodule

`default_nettype wire

// ===== rtl/core/atrlc_line_store.sv =====
// Line store: one write port and one read port, read data registered.
// Depends on atrlc_pkg for depth and widths.
`default_nettype none

module atrlc_line_store (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire [atrlc_pkg::ADDR_W-1:0]  wr_addr,
   input  wire [atrlc_pkg::BYTE_W-1:0]  wr_data,
   input  wire                          rd_en,
   input  wire [atrlc_pkg::ADDR_W-1:0]  rd_addr,
   output logic [atrlc_pkg::BYTE_W-1:0] rd_data
);
   import atrlc_pkg::*;

   logic [BYTE_W-1:0] mem [BUF_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/atrlc_tracker.sv =====
// Line tracker: fill position, line start, information count and the
// incremental pattern match. Decodes each accepted beat into a cmd_type.
// Depends on atrlc_pkg.
`default_nettype none

module atrlc_tracker (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         accept,
   input  wire [atrlc_pkg::FUNC_W-1:0] func,
   input  wire [atrlc_pkg::BYTE_W-1:0] rx_byte,
   input  wire [atrlc_pkg::IDX_W-1:0]  read_index,
   output atrlc_pkg::cmd_type          cmd
);
   import atrlc_pkg::*;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] start_ff, start_in;
   logic [FILL_W-1:0] info_ff, info_in;
   logic              cr_ff, cr_in;
   logic [NPAT-1:0]   alive_ff, alive_in;

   logic [FILL_W-1:0] offset;
   logic [FILL_W-1:0] fill_inc;
   logic [FILL_W-1:0] line_len;
   logic [NPAT-1:0]   alive_upd;
   logic [NPAT-1:0]   final_hit;
   logic              found;
   logic [CODE_W-1:0] found_code;

   assign offset   = fill_ff - start_ff;
   assign fill_inc = fill_ff + 1'b1;
   assign line_len = fill_inc - start_ff;

   // Each pattern survives while every byte of the line so far agrees with it.
   always_comb begin
      for (int p = 0; p < NPAT; p++) begin
         alive_upd[p] = alive_ff[p];
         if (offset < FILL_W'(PAT_LEN[p])
             && PAT_TEXT[p][offset[3:0]] != rx_byte) begin
            alive_upd[p] = 1'b0;
         end
         final_hit[p] = alive_upd[p] && (line_len >= FILL_W'(PAT_LEN[p]));
      end
   end

   // Lowest matching pattern wins.
   always_comb begin
      found      = 1'b0;
      found_code = CODE_OK;
      for (int p = NPAT - 1; p >= 0; p--) begin
         if (final_hit[p]) begin
            found      = 1'b1;
            found_code = CODE_W'(p);
         end
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      start_in = start_ff;
      info_in  = info_ff;
      cr_in    = cr_ff;
      alive_in = alive_ff;

      cmd         = '0;
      cmd.wr_addr = fill_ff[ADDR_W-1:0];
      cmd.wr_data = rx_byte;
      cmd.rd_addr = ADDR_W'(read_index);
      cmd.rd_hit  = CMP_W'(read_index) < CMP_W'(fill_ff);

      unique case (func)
         FUNC_SILENCE: begin
            cmd.emit = 1'b1;
            cmd.code = CODE_NORESP;
            cmd.len  = LEN_W'(info_ff);
            fill_in  = '0;
            start_in = '0;
            info_in  = '0;
            cr_in    = 1'b0;
            alive_in = ALL_ALIVE;
         end
         FUNC_READ: begin
            cmd.emit  = 1'b1;
            cmd.code  = CODE_READ;
            cmd.rd_en = 1'b1;
         end
         FUNC_BYTE: begin
            if (fill_ff == '0 && (rx_byte == CHAR_CR || rx_byte == CHAR_LF)) begin
               // Delimiters ahead of any stored byte are dropped.
            end else if (fill_ff == FILL_W'(BUF_DEPTH)) begin
               cmd.emit = 1'b1;
               cmd.code = CODE_OVERFLOW;
               cmd.len  = LEN_W'(info_ff);
               fill_in  = '0;
               start_in = '0;
               info_in  = '0;
               cr_in    = 1'b0;
               alive_in = ALL_ALIVE;
            end else begin
               cmd.wr_en = 1'b1;
               fill_in   = fill_inc;
               cr_in     = (rx_byte == CHAR_CR);
               alive_in  = alive_upd;
               if (rx_byte == CHAR_LF && cr_ff) begin
                  start_in = fill_inc;
                  alive_in = ALL_ALIVE;
                  if (line_len != FILL_W'(2)) begin
                     if (found) begin
                        cmd.emit = 1'b1;
                        cmd.code = found_code;
                        cmd.len  = LEN_W'(info_ff);
                        fill_in  = '0;
                        start_in = '0;
                        info_in  = '0;
                        cr_in    = 1'b0;
                     end else begin
                        info_in = fill_inc;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (!accept) begin
         cmd.emit  = 1'b0;
         cmd.wr_en = 1'b0;
         cmd.rd_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         start_ff <= '0;
         info_ff  <= '0;
         cr_ff    <= 1'b0;
         alive_ff <= ALL_ALIVE;
      end else if (accept) begin
         fill_ff  <= fill_in;
         start_ff <= start_in;
         info_ff  <= info_in;
         cr_ff    <= cr_in;
         alive_ff <= alive_in;
      end
   end

endmodule

`default_nettype wire

// ===== bench/atrlc_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// Line classifier scoreboard: predicts the response beat of each accepted
// request beat and checks response beats in order. Depends on atrlc_pkg.
package atrlc_tb_pkg;
   import atrlc_pkg::*;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] data;
   } reply_type;

   localparam logic [CODE_W-1:0] PATTERN_CODE [NPAT] =
      '{CODE_OK, CODE_ERROR, CODE_RING, CODE_READY, CODE_HWFAIL};

   class reply_tracker;
      logic [BYTE_W-1:0] line_bytes [BUF_DEPTH];
      int                fill;
      int                line_start;
      int                info_count;
      bit                last_cr;
      logic [NPAT-1:0]   alive;
      reply_type         pending [$];
      int                failures;

      function new();
         failures = 0;
         clear_line();
      endfunction

      function void clear_line();
         fill       = 0;
         line_start = 0;
         info_count = 0;
         last_cr    = 1'b0;
         alive      = ALL_ALIVE;
      endfunction

      function void push_reply(logic [CODE_W-1:0] code, int len, logic [BYTE_W-1:0] data);
         reply_type r;
         r.code = code;
         r.len  = len[LEN_W-1:0];
         r.data = data;
         pending.push_back(r);
      endfunction

      function void take_byte(logic [BYTE_W-1:0] b);
         int off;
         int line_len;
         int p;
         bit was_cr;
         if (fill == 0 && (b == CHAR_CR || b == CHAR_LF)) return;
         if (fill >= BUF_DEPTH) begin
            push_reply(CODE_OVERFLOW, info_count, 8'h00);
            clear_line();
            return;
         end
         // A pattern stays alive while every byte of the line so far agrees with it.
         off = fill - line_start;
         for (p = 0; p < NPAT; p++) begin
            if (off < PAT_LEN[p]) begin
               if (PAT_TEXT[p][off] != b) alive[p] = 1'b0;
            end
         end
         line_bytes[fill] = b;
         fill++;
         was_cr  = last_cr;
         last_cr = (b == CHAR_CR);
         if (b == CHAR_LF && was_cr) begin
            line_len = fill - line_start;
            if (line_len != 2) begin
               for (p = 0; p < NPAT; p++) begin
                  if (alive[p] && line_len >= PAT_LEN[p]) begin
                     push_reply(PATTERN_CODE[p], info_count, 8'h00);
                     clear_line();
                     return;
                  end
               end
               info_count = fill;
            end
            line_start = fill;
            alive      = ALL_ALIVE;
         end
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] b,
                                 logic [IDX_W-1:0] idx);
         case (func)
            FUNC_BYTE: take_byte(b);
            FUNC_SILENCE: begin
               push_reply(CODE_NORESP, info_count, 8'h00);
               clear_line();
            end
            FUNC_READ: push_reply(CODE_READ, 0, (idx < fill) ? line_bytes[idx] : 8'h00);
            default: ;
         endcase
      endfunction

      function void check_reply(logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                                logic [BYTE_W-1:0] data);
         reply_type want;
         if (pending.size() == 0) begin
            $error("unexpected response beat: result_code %0d", code);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (code !== want.code) begin
            $error("result_code: expected %0d, got %0d", want.code, code);
            failures++;
         end
         if (len !== want.len) begin
            $error("info_length: expected %0d, got %0d", want.len, len);
            failures++;
         end
         if (data !== want.data) begin
            $error("data_byte: expected %0d, got %0d", want.data, data);
            failures++;
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the line classifier testbench: clock, reset, request and response
// drivers, watchdog. Depends on atrlc_pkg, atrlc_ifs and atrlc_tb_pkg.
module tb;
   import atrlc_pkg::*;
   import atrlc_tb_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1700;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 120;

   logic clock = 1'b0;
   logic reset;

   atrlc_req_if req_ch ();
   atrlc_rsp_if rsp_ch ();

   at_response_line_classifier u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   reply_tracker sb = new();

   int items_sent = 0;
   int rsp_beats  = 0;
   bit calm       = 1'b0;
   bit held_off   = 1'b0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_reply(rsp_ch.result_code, rsp_ch.info_length, rsp_ch.data_byte);
         rsp_beats++;
      end
   end

   // Response side: random stalls, plus one long hold-off while requests keep coming.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && rsp_beats >= 150) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 13);
            @(posedge clock);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_item(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] b,
                            logic [IDX_W-1:0] idx);
      if (!calm && $urandom_range(99) < 15) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= func;
      req_ch.rx_byte    <= b;
      req_ch.read_index <= idx;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(func, b, idx);
      if (func != FUNC_UNUSED) items_sent++;
   endtask

   task automatic send_byte(logic [BYTE_W-1:0] b);
      send_item(FUNC_BYTE, b, IDX_W'($urandom));
   endtask

   task automatic send_crlf();
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   task automatic send_read(logic [IDX_W-1:0] idx);
      send_item(FUNC_READ, BYTE_W'($urandom), idx);
   endtask

   task automatic send_silence();
      send_item(FUNC_SILENCE, BYTE_W'($urandom), IDX_W'($urandom));
   endtask

   function automatic logic [BYTE_W-1:0] text_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(255)); while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   task automatic send_info(int n);
      repeat (n) send_byte(text_byte());
      send_crlf();
   endtask

   // A final result line; a corrupted one flips bit 5 (the case of a letter) of one byte.
   task automatic send_final(int p, bit corrupt);
      int n;
      int bad;
      logic [BYTE_W-1:0] c;
      n   = (p == NPAT - 1) ? PAT_MAX : PAT_LEN[p] - 2;
      bad = corrupt ? $urandom_range(0, n - 1) : -1;
      for (int k = 0; k < n; k++) begin
         c = PAT_TEXT[p][k];
         if (k == bad) c = c ^ 8'h20;
         send_byte(c);
      end
      if (p == NPAT - 1 && $urandom_range(1)) repeat ($urandom_range(1, 6)) send_byte(text_byte());
      send_crlf();
   endtask

   task automatic send_prefix(int p);
      int n;
      n = (p == NPAT - 1) ? PAT_MAX - 1 : PAT_LEN[p] - 3;
      n = $urandom_range(1, n);
      for (int k = 0; k < n; k++) send_byte(PAT_TEXT[p][k]);
      send_crlf();
   endtask

   task automatic send_noise();
      int p;
      repeat ($urandom_range(1, 6)) begin
         p = $urandom_range(NPAT - 1);
         case ($urandom_range(3))
            0: send_byte(CHAR_CR);
            1: send_byte(CHAR_LF);
            2: send_byte(BYTE_W'($urandom));
            default: send_byte(PAT_TEXT[p][$urandom_range(PAT_LEN[p] - 1)]);
         endcase
      end
   endtask

   task automatic send_reads();
      int top;
      repeat ($urandom_range(1, 3)) begin
         top = (sb.fill > 255) ? 255 : sb.fill;
         if ($urandom_range(1)) send_read(IDX_W'($urandom_range(0, top)));
         else send_read(IDX_W'($urandom));
      end
   endtask

   // Fills the store with one information line ending exactly at the last
   // entry, reads the top, then one more byte overflows it.
   task automatic fill_exact();
      send_silence();
      repeat (BUF_DEPTH - 2) send_byte(text_byte());
      send_crlf();
      repeat (4) send_read(IDX_W'($urandom_range(128, 255)));
      send_read(8'hFF);
      send_byte(BYTE_W'($urandom));
   endtask

   task automatic fill_long();
      send_silence();
      repeat (BUF_DEPTH + 1 + $urandom_range(0, 20)) send_byte(text_byte());
   endtask

   initial begin
      bit did_exact;
      bit did_long;
      int pick;
      did_exact = 1'b0;
      did_long  = 1'b0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.func       <= FUNC_BYTE;
      req_ch.rx_byte    <= 8'h00;
      req_ch.read_index <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: delimiters dropped while empty, extreme bytes, blank line,
      // reads inside and past the fill, unused function, OK after an
      // information line, silence, and an LF that does not follow a CR.
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      send_byte("A");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_crlf();
      send_crlf();
      send_read(8'd4);
      send_read(8'hFF);
      send_read(8'd5);
      send_item(FUNC_UNUSED, BYTE_W'($urandom), IDX_W'($urandom));
      send_byte("O");
      send_byte("K");
      send_crlf();
      send_silence();
      send_byte("X");
      send_silence();
      send_byte("E");
      send_byte(CHAR_LF);
      send_crlf();
      send_silence();

      while (items_sent < ITEM_TARGET) begin
         calm = (items_sent >= 800 && items_sent < 1100);
         if (!did_exact && items_sent >= 450) begin
            did_exact = 1'b1;
            fill_exact();
         end
         if (!did_long && items_sent >= 1150) begin
            did_long = 1'b1;
            fill_long();
         end
         pick = $urandom_range(99);
         if (pick < 30) begin
            repeat ($urandom_range(0, 2)) send_info($urandom_range(1, 10));
            send_final($urandom_range(NPAT - 1), $urandom_range(99) < 20);
         end else if (pick < 48) send_info($urandom_range(0, 12));
         else if (pick < 63) send_reads();
         else if (pick < 72) send_silence();
         else if (pick < 84) send_noise();
         else if (pick < 88) send_item(FUNC_UNUSED, BYTE_W'($urandom), IDX_W'($urandom));
         else send_prefix($urandom_range(NPAT - 1));
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
